[src/block_map_run_coalescer_defines.svh]
// Assertion macros used by the checker file.
`ifndef BLOCK_MAP_RUN_COALESCER_DEFINES_SVH
`define BLOCK_MAP_RUN_COALESCER_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define BMRC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BMRC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[src/bmrc_pkg.sv]
`default_nettype none

package bmrc_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned BLOCK_W    = 48;
  localparam int unsigned COUNT_W    = 15;
  localparam int unsigned BYTE_W     = 64;
  localparam int unsigned LOG_W      = 3;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  // Smallest block is 1 KiB.
  localparam logic [SHAMT_W-1:0] BASE_BLOCK_SHIFT = 5'd10;

  typedef enum logic [OP_W-1:0] {
    OP_START  = 3'd0,
    OP_EXTENT = 3'd1,
    OP_DATA   = 3'd2,
    OP_META   = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTITION_BASE = 1'b0,
    CFG_BLOCK_SIZE_LOG = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CAND_NONE,
    CAND_OFFER,
    CAND_FINISH,
    CAND_START
  } cand_kind_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [BLOCK_W-1:0] block_number;
    logic [COUNT_W-1:0] block_count;
    logic               uninitialized;
    logic [BYTE_W-1:0]  file_size;
  } item_t;

  typedef struct packed {
    cand_kind_e        kind;
    logic [BYTE_W-1:0] offset;
    logic [BYTE_W-1:0] length;
  } cand_t;

endpackage

`default_nettype wire

[src/bmrc_item_if.sv]
`default_nettype none

interface bmrc_item_if;
  import bmrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [BLOCK_W-1:0] block_number;
  logic [COUNT_W-1:0] block_count;
  logic               uninitialized;
  logic [BYTE_W-1:0]  file_size;

  modport source (
    output valid, operation, block_number, block_count, uninitialized, file_size,
    input  ready
  );

  modport sink (
    input  valid, operation, block_number, block_count, uninitialized, file_size,
    output ready
  );
endinterface

`default_nettype wire

[src/bmrc_run_if.sv]
`default_nettype none

interface bmrc_run_if;
  import bmrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] run_offset;
  logic [BYTE_W-1:0] run_length;

  modport source (
    output valid, run_offset, run_length,
    input  ready
  );

  modport sink (
    input  valid, run_offset, run_length,
    output ready
  );
endinterface

`default_nettype wire

[src/bmrc_map.sv]
`default_nettype none

module bmrc_map (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          consume,
  input  wire bmrc_pkg::item_t               item_q,
  input  wire logic [bmrc_pkg::BYTE_W-1:0]   partition_base,
  input  wire logic [bmrc_pkg::LOG_W-1:0]    block_size_log,
  output bmrc_pkg::cand_t                    cand
);
  import bmrc_pkg::*;

  logic [BYTE_W-1:0]  bytes_remaining;
  logic [BYTE_W-1:0]  bytes_remaining_next;

  logic [SHAMT_W-1:0] shamt;
  logic [BYTE_W-1:0]  bs;
  logic [BYTE_W-1:0]  blk_off;
  logic [BYTE_W-1:0]  ext_bytes;
  logic [BYTE_W-1:0]  take_ext;
  logic [BYTE_W-1:0]  first_blk;
  logic [BYTE_W-1:0]  ext_len;
  logic [BYTE_W-1:0]  take_dat;
  logic [BYTE_W-1:0]  run_off;
  logic               blk_zero;

  always_comb begin
    shamt     = BASE_BLOCK_SHIFT + SHAMT_W'(block_size_log);
    bs        = BYTE_W'(1) << shamt;
    blk_off   = BYTE_W'(item_q.block_number) << shamt;
    ext_bytes = BYTE_W'(item_q.block_count) << shamt;
    blk_zero  = (item_q.block_number == '0);
    take_ext  = (ext_bytes < bytes_remaining) ? ext_bytes : bytes_remaining;
    first_blk = (bs < take_ext) ? bs : take_ext;
    // Block zero: the first block is consumed but never mapped.
    ext_len   = blk_zero ? (take_ext - first_blk) : take_ext;
    take_dat  = (bs < bytes_remaining) ? bs : bytes_remaining;
    run_off   = partition_base + (blk_zero ? bs : blk_off);
  end

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    cand.kind   = CAND_NONE;
    cand.offset = run_off;
    cand.length = ext_len;
    case (op_e'(item_q.operation))
      OP_START: begin
        bytes_remaining_next = item_q.file_size;
        cand.kind = CAND_START;
      end
      OP_EXTENT: begin
        bytes_remaining_next = bytes_remaining - take_ext;
        if (!item_q.uninitialized && ext_len != '0) begin
          cand.kind = CAND_OFFER;
        end
      end
      OP_DATA: begin
        cand.length = take_dat;
        if (!blk_zero) begin
          bytes_remaining_next = bytes_remaining - take_dat;
          if (take_dat != '0) begin
            cand.kind = CAND_OFFER;
          end
        end
      end
      OP_META: begin
        cand.length = bs;
        if (!blk_zero && bytes_remaining != '0) begin
          cand.kind = CAND_OFFER;
        end
      end
      OP_FINISH: begin
        cand.kind = CAND_FINISH;
      end
      default: begin
        cand.kind = CAND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
    end else if (consume) begin
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

[src/bmrc_coalesce.sv]
`default_nettype none

module bmrc_coalesce (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            consume,
  input  wire bmrc_pkg::cand_t cand,
  output logic                 can_accept,
  bmrc_run_if.source           run
);
  import bmrc_pkg::*;

  logic              pend_valid;
  logic              pend_valid_next;
  logic [BYTE_W-1:0] pend_offset;
  logic [BYTE_W-1:0] pend_offset_next;
  logic [BYTE_W-1:0] pend_length;
  logic [BYTE_W-1:0] pend_length_next;
  logic [BYTE_W-1:0] pend_end;
  logic [BYTE_W-1:0] pend_end_next;
  logic              emit;
  logic              hit;

  logic              out_valid;
  logic [BYTE_W-1:0] out_offset;
  logic [BYTE_W-1:0] out_length;

  assign can_accept = !out_valid || run.ready;
  assign hit        = pend_valid && (pend_end == cand.offset);

  always_comb begin
    pend_valid_next  = pend_valid;
    pend_offset_next = pend_offset;
    pend_length_next = pend_length;
    pend_end_next    = pend_end;
    emit             = 1'b0;
    case (cand.kind)
      CAND_OFFER: begin
        if (hit) begin
          pend_length_next = pend_length + cand.length;
          pend_end_next    = pend_end + cand.length;
        end else begin
          emit             = pend_valid;
          pend_valid_next  = 1'b1;
          pend_offset_next = cand.offset;
          pend_length_next = cand.length;
          pend_end_next    = cand.offset + cand.length;
        end
      end
      CAND_FINISH: begin
        emit            = pend_valid;
        pend_valid_next = 1'b0;
      end
      CAND_START: begin
        pend_valid_next = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (consume) begin
        pend_valid <= pend_valid_next;
      end
      if (consume && emit) begin
        out_valid <= 1'b1;
      end else if (run.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      pend_offset <= pend_offset_next;
      pend_length <= pend_length_next;
      pend_end    <= pend_end_next;
    end
    if (consume && emit) begin
      out_offset <= pend_offset;
      out_length <= pend_length;
    end
  end

  assign run.valid      = out_valid;
  assign run.run_offset = out_offset;
  assign run.run_length = out_length;

endmodule

`default_nettype wire

[src/block_map_run_coalescer.sv]
// Block map run coalescer.
// The item channel carries one block map entry per beat: start of a file
// (loads the file size), extent entry, data block pointer, metadata block
// or finish. The run channel carries finished contiguous device byte runs
// (offset and length); adjacent runs are merged before they leave.
// Configuration (partition base, block size log) is written through
// cfg_wr_en / cfg_index / cfg_data; the user must write it only while no
// item is in flight; the block itself does not enforce this.
// Throughput: one item per cycle while the run channel does not stall.
// An item waits in the input register; the map and merge logic loads any
// run it releases into the run register when the item is consumed. A run
// is only released by the item that breaks it, or by finish, never earlier.
// Reset (synchronous, rst high) clears the remaining byte count, the
// pending run, the input register, the output register and the config.
// Run channel stall: the run register holds its beat; an empty input register
// still takes one more item, then item.ready drops until the run leaves.
`default_nettype none

module block_map_run_coalescer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bmrc_item_if.sink                            item,
  bmrc_run_if.source                           run,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bmrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bmrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmrc_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0] partition_base;
  logic [LOG_W-1:0]  block_size_log;

  // Input register.
  logic  in_valid;
  item_t in_item;

  logic  accept;
  logic  consume;
  logic  can_accept;
  cand_t cand;

  // Advance the input register whenever the merge stage can take a result.
  assign consume    = in_valid && can_accept;
  assign item.ready = !in_valid || consume;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_base <= '0;
      block_size_log <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_e'(cfg_index))
        CFG_PARTITION_BASE: partition_base <= cfg_data[BYTE_W-1:0];
        CFG_BLOCK_SIZE_LOG: block_size_log <= cfg_data[LOG_W-1:0];
        default: begin
          partition_base <= partition_base;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  // Payload needs no reset; capture on every accepted beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.operation     <= item.operation;
      in_item.block_number  <= item.block_number;
      in_item.block_count   <= item.block_count;
      in_item.uninitialized <= item.uninitialized;
      in_item.file_size     <= item.file_size;
    end
  end

  // Decode the entry, clip it against the remaining size, form the run.
  bmrc_map u_map (
    .clk            (clk),
    .rst            (rst),
    .consume        (consume),
    .item_q         (in_item),
    .partition_base (partition_base),
    .block_size_log (block_size_log),
    .cand           (cand)
  );

  // Merge with the pending run and drive the run register.
  bmrc_coalesce u_coalesce (
    .clk        (clk),
    .rst        (rst),
    .consume    (consume),
    .cand       (cand),
    .can_accept (can_accept),
    .run        (run)
  );

endmodule

`default_nettype wire

[src/bmrc_checker.sv]
`default_nettype none
`include "block_map_run_coalescer_defines.svh"

module bmrc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         item_valid,
  input wire logic                         item_ready,
  input wire logic                         run_valid,
  input wire logic                         run_ready,
  input wire logic [bmrc_pkg::BYTE_W-1:0]  run_offset,
  input wire logic [bmrc_pkg::BYTE_W-1:0]  run_length
);
  import bmrc_pkg::*;

  logic run_stall;
  logic item_beat;

  assign run_stall = run_valid && !run_ready;
  assign item_beat = item_valid && item_ready;

  // Reset empties the run register.
  `BMRC_ASSERT_ALWAYS(a_reset_clears_run, clk, rst |=> !run_valid, "run valid after reset")

  // A stalled run beat stays up.
  `BMRC_ASSERT(a_run_hold, clk, rst, run_stall |=> run_valid, "run beat dropped while stalled")

  // A stalled run beat keeps its payload.
  `BMRC_ASSERT(a_run_stable, clk, rst, run_stall |=> ($stable(run_offset) && $stable(run_length)), "run payload changed while stalled")

  // Only one item may be buffered behind a stalled run.
  `BMRC_ASSERT(a_one_deep, clk, rst, (run_stall && item_beat) ##1 run_stall |-> !item_ready, "second item taken behind stalled run")

endmodule

bind block_map_run_coalescer bmrc_checker u_bmrc_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .run_valid  (run.valid),
  .run_ready  (run.ready),
  .run_offset (run.run_offset),
  .run_length (run.run_length)
);

`default_nettype wire
